// ----- rtl/terrain_cell_texture_layers_defines.svh -----
// ----------------------------------------------------------------------------
// terrain cell texture layers: assertion macros
// Shared assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_CELL_TEXTURE_LAYERS_DEFINES_SVH
`define TERRAIN_CELL_TEXTURE_LAYERS_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TCTL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tctl assertion failed");

// next-cycle implication
`define TCTL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tctl assertion failed");

`else

`define TCTL_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCTL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/tctl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctl_pkg
// Types, constants and lookup tables of the terrain cell texture layer block.
// ----------------------------------------------------------------------------
package tctl_pkg;

  localparam int CHUNK_COORD_BITS_DEF = 10;

  typedef logic [7:0]  tex_t;
  typedef logic [11:0] pos_u_t;
  typedef logic [14:0] pos_v_t;
  typedef logic [3:0][7:0] tex_quad_t;

  typedef struct packed {
    pos_u_t u;
    pos_v_t v;
  } layer_pos_t;

  typedef layer_pos_t [2:0] layer_set_t;

  // corner codes
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  // generator constants
  localparam logic [31:0] LCG_MULT  = 32'd48271;
  localparam int          SCHRAGE_Q = 44488;
  localparam logic [31:0] SIGN_FIX  = 32'h8000_0000;
  localparam logic [31:0] ZERO_SUB  = 32'd123459876;

  // s / 44488 = (s >> 3) / 5561, done as multiply by a rounded-up reciprocal
  localparam int Q_POW2_SHIFT  = 3;
  localparam int Q_ODD         = SCHRAGE_Q / (1 << Q_POW2_SHIFT);
  localparam int DIVIDEND_BITS = 32 - Q_POW2_SHIFT;
  localparam int ODD_BITS      = $clog2(Q_ODD);
  localparam int RECIP_SHIFT   = DIVIDEND_BITS + ODD_BITS;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + 64'(Q_ODD) - 64'd1) / 64'(Q_ODD);
  localparam int RECIP_BITS    = $clog2(RECIP_VAL + 1);
  localparam int PROD_BITS     = DIVIDEND_BITS + RECIP_BITS;
  localparam int QUO_BITS      = PROD_BITS - RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_BITS'(RECIP_VAL);

  // atlas geometry in half pixels
  localparam logic [7:0]  BORDER_NEAR  = 8'd17;
  localparam logic [7:0]  BORDER_FAR   = 8'd239;
  localparam int          NEUTRAL_HALF = 273;
  localparam layer_pos_t  NEUTRAL_POS  = '{u: pos_u_t'(NEUTRAL_HALF),
                                           v: pos_v_t'(NEUTRAL_HALF)};
  localparam int          ROT_BIT      = 15;

  // atlas position of one layer at one corner
  function automatic layer_pos_t layer_pos(tex_t tex, logic [1:0] quad, logic rot,
                                           logic [1:0] corner);
    logic [8:0]  tile;
    logic [1:0]  eff;
    layer_pos_t  p;
    tile = 9'(tex) + 9'd1;
    eff  = corner ^ {rot, rot};
    p.u  = {tile[2:0], quad[0], (eff[0] ? BORDER_FAR : BORDER_NEAR)};
    p.v  = {tile[8:3], quad[1], (eff[1] ? BORDER_FAR : BORDER_NEAR)};
    return p;
  endfunction

  // primary variant per corner mask: rotation flag and quadrant
  function automatic logic [15:0] primary_entry(logic [3:0] m);
    logic [15:0] e;
    case (m)
      4'd0:    e = 16'h8000;
      4'd1:    e = 16'h8003;
      4'd2:    e = 16'h0001;
      4'd3:    e = 16'h8000;
      4'd4:    e = 16'h8001;
      4'd5:    e = 16'h0002;
      4'd6:    e = 16'h8001;
      4'd7:    e = 16'h0002;
      4'd8:    e = 16'h0003;
      4'd9:    e = 16'h8003;
      4'd10:   e = 16'h8002;
      4'd11:   e = 16'h8000;
      4'd15:   e = 16'h8002;
      default: e = 16'h0000;
    endcase
    return e;
  endfunction

  // secondary variant exists for this mask
  function automatic logic second_ok(logic [3:0] m);
    logic ok;
    case (m)
      4'd0, 4'd6, 4'd7, 4'd9, 4'd11, 4'd13, 4'd14, 4'd15: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // secondary variant per corner mask
  function automatic logic [15:0] second_entry(logic [3:0] m);
    logic [15:0] e;
    case (m)
      4'd6, 4'd7, 4'd14: e = 16'h0001;
      4'd9, 4'd11:       e = 16'h0003;
      4'd13:             e = 16'h8003;
      4'd15:             e = 16'h0002;
      default:           e = 16'h0000;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/tctl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctl channel interfaces
// Valid/ready channels for terrain cells in and corner results out.
// ----------------------------------------------------------------------------
interface tctl_cell_if #(
  parameter int COORD_BITS = tctl_pkg::CHUNK_COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  chunk_start;
  logic [COORD_BITS-1:0] chunk_x;
  logic [COORD_BITS-1:0] chunk_z;
  logic                  in_map;
  tctl_pkg::tex_t        tex_top_left;
  tctl_pkg::tex_t        tex_top_right;
  tctl_pkg::tex_t        tex_bottom_left;
  tctl_pkg::tex_t        tex_bottom_right;

  modport source (output valid, chunk_start, chunk_x, chunk_z, in_map, tex_top_left,
                  tex_top_right, tex_bottom_left, tex_bottom_right, input ready);
  modport sink (input valid, chunk_start, chunk_x, chunk_z, in_map, tex_top_left,
                tex_top_right, tex_bottom_left, tex_bottom_right, output ready);
endinterface

interface tctl_corner_if;
  logic             valid;
  logic             ready;
  logic [1:0]       corner;
  tctl_pkg::pos_u_t layer0_u;
  tctl_pkg::pos_v_t layer0_v;
  tctl_pkg::pos_u_t layer1_u;
  tctl_pkg::pos_v_t layer1_v;
  tctl_pkg::pos_u_t layer2_u;
  tctl_pkg::pos_v_t layer2_v;
  logic             last;

  modport source (output valid, corner, layer0_u, layer0_v, layer1_u, layer1_v,
                  layer2_u, layer2_v, last, input ready);
  modport sink (input valid, corner, layer0_u, layer0_v, layer1_u, layer1_v,
                layer2_u, layer2_v, last, output ready);
endinterface

// ----- rtl/tctl_rng.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctl_rng
// Per-cell random generator: optional reseed from chunk coordinates, then one
// multiplicative step with the division done by a reciprocal multiply.
// ----------------------------------------------------------------------------
`include "terrain_cell_texture_layers_defines.svh"

module tctl_rng #(
  parameter int CHUNK_COORD_BITS = tctl_pkg::CHUNK_COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        chunk_start,
  input  logic [CHUNK_COORD_BITS-1:0] chunk_x,
  input  logic [CHUNK_COORD_BITS-1:0] chunk_z,
  output logic [1:0]                  quad
);
  import tctl_pkg::*;

  logic [31:0]          state;
  logic [31:0]          state_next;
  logic [31:0]          base;
  logic [31:0]          prod_a;
  logic [PROD_BITS-1:0] recip_prod;
  logic [QUO_BITS-1:0]  quo;
  logic [31:0]          mod_term;
  logic [31:0]          diff;
  logic [31:0]          folded;

  // seed select and generator step
  always_comb begin
    base       = chunk_start ? ((32'(chunk_x) << 16) ^ 32'(chunk_z)) : state;
    prod_a     = base * LCG_MULT;
    recip_prod = PROD_BITS'(base[31:Q_POW2_SHIFT]) * PROD_BITS'(DIV_RECIP);
    quo        = recip_prod[PROD_BITS-1:RECIP_SHIFT];
    // times 0x7fffffff is (q << 31) - q
    mod_term   = (32'(quo) << 31) - 32'(quo);
    diff       = prod_a - mod_term;
    folded     = diff[31] ? (diff + SIGN_FIX) : diff;
    state_next = (folded == '0) ? ZERO_SUB : folded;
  end

  assign quad = state_next[1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  `TCTL_ASSERT_NXT(a_state_nonzero, clk, rst, step, state != '0)
  `TCTL_ASSERT_NXT(a_state_31bit, clk, rst, step, !state[31])

endmodule

// ----- rtl/tctl_layers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctl_layers
// Groups the four corner textures into sorted distinct keys with corner masks
// and picks the three atlas layers for one corner.
// ----------------------------------------------------------------------------
module tctl_layers (
  input  tctl_pkg::tex_quad_t  tex,
  input  logic [1:0]           rq,
  input  logic [1:0]           corner,
  output tctl_pkg::layer_set_t layers
);
  import tctl_pkg::*;

  logic [3:0][3:0] same;
  logic [3:0]      first;
  logic [3:0][1:0] rank;
  logic [2:0]      n_dist;
  tex_t [2:0]      key;
  logic [2:0][3:0] kmask;
  logic [15:0]     prim1;
  logic [15:0]     prim2;
  logic [15:0]     sec;

  // equality masks, first occurrence and sort rank of each corner texture
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        same[i][j] = (tex[i] == tex[j]);
      end
    end
    n_dist = '0;
    for (int i = 0; i < 4; i++) begin
      first[i] = 1'b1;
      for (int j = 0; j < 4; j++) begin
        if (j < i && same[i][j]) begin
          first[i] = 1'b0;
        end
      end
      n_dist = n_dist + 3'(first[i]);
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (first[j] && tex[j] < tex[i]) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
  end

  // distinct keys in ascending order, fourth one dropped
  always_comb begin
    key   = '0;
    kmask = '0;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 4; i++) begin
        if (first[i] && rank[i] == 2'(r)) begin
          key[r]   = key[r] | tex[i];
          kmask[r] = kmask[r] | same[i];
        end
      end
    end
  end

  // layer selection
  always_comb begin
    prim1     = primary_entry(kmask[1]);
    prim2     = primary_entry(kmask[2]);
    sec       = second_entry(kmask[1]);
    layers[0] = layer_pos(key[0], rq, 1'b0, corner);
    layers[1] = layer_pos(key[1], prim1[1:0], prim1[ROT_BIT], corner);
    case (n_dist)
      3'd1: begin
        layers[1] = NEUTRAL_POS;
        layers[2] = NEUTRAL_POS;
      end
      3'd2: begin
        if (second_ok(kmask[1])) begin
          layers[2] = layer_pos(key[1], sec[1:0], sec[ROT_BIT], corner);
        end else begin
          layers[2] = NEUTRAL_POS;
        end
      end
      default: begin
        layers[2] = layer_pos(key[2], prim2[1:0], prim2[ROT_BIT], corner);
      end
    endcase
  end

endmodule

// ----- rtl/terrain_cell_texture_layers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_cell_texture_layers
// Per-cell texture layer generator: one terrain cell in, four corner results
// with three atlas layer positions each out.
// ----------------------------------------------------------------------------
//   channel   role    item
//   -------   -----   ---------------------------------------------------
//   cells     sink    chunk start and coords, in-map flag, corner textures
//   corners   source  corner code, three layer u/v in half pixels, last
//
// An out-of-map cell gives no corner results; one can be taken every cycle.
// An in-map cell gives four corner results, one per cycle unless corners
// stalls, from the cell register and corner count via the output register.
// The next cell is taken in the cycle its predecessor's last corner is loaded.
// Reset clears the random state, the cell and output valid flags and the
// corner count. A stall on corners holds the output register and the cell.
// ----------------------------------------------------------------------------
`include "terrain_cell_texture_layers_defines.svh"

module terrain_cell_texture_layers #(
  parameter int CHUNK_COORD_BITS = tctl_pkg::CHUNK_COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tctl_cell_if.sink    cells,
  tctl_corner_if.source corners
);
  import tctl_pkg::*;

  logic       cell_valid;
  tex_quad_t  cell_tex;
  logic [1:0] cell_rq;
  logic [1:0] corner_cnt;
  logic       out_valid;
  logic [1:0] out_corner;
  layer_set_t out_layers;
  logic       out_last;
  logic       in_fire;
  logic       load;
  logic       cell_done;
  logic [1:0] rq_next;
  layer_set_t layers;

  // handshake control
  assign load        = cell_valid && (!out_valid || corners.ready);
  assign cell_done   = load && (corner_cnt == CORNER_BR);
  assign cells.ready = !cell_valid || cell_done;
  assign in_fire     = cells.valid && cells.ready;

  // random generator steps on every accepted item
  tctl_rng #(
    .CHUNK_COORD_BITS(CHUNK_COORD_BITS)
  ) u_rng (
    .clk        (clk),
    .rst        (rst),
    .step       (in_fire),
    .chunk_start(cells.chunk_start),
    .chunk_x    (cells.chunk_x),
    .chunk_z    (cells.chunk_z),
    .quad       (rq_next)
  );

  // layer selection for the current corner
  tctl_layers u_layers (
    .tex   (cell_tex),
    .rq    (cell_rq),
    .corner(corner_cnt),
    .layers(layers)
  );

  // cell register and corner count
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      corner_cnt <= CORNER_TL;
    end else begin
      if (in_fire) begin
        cell_valid <= cells.in_map;
      end else if (cell_done) begin
        cell_valid <= 1'b0;
      end
      if (load) begin
        corner_cnt <= corner_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cell_tex[CORNER_TL] <= cells.tex_top_left;
      cell_tex[CORNER_TR] <= cells.tex_top_right;
      cell_tex[CORNER_BL] <= cells.tex_bottom_left;
      cell_tex[CORNER_BR] <= cells.tex_bottom_right;
      cell_rq             <= rq_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (corners.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_corner <= corner_cnt;
      out_layers <= layers;
      out_last   <= (corner_cnt == CORNER_BR);
    end
  end

  assign corners.valid    = out_valid;
  assign corners.corner   = out_corner;
  assign corners.layer0_u = out_layers[0].u;
  assign corners.layer0_v = out_layers[0].v;
  assign corners.layer1_u = out_layers[1].u;
  assign corners.layer1_v = out_layers[1].v;
  assign corners.layer2_u = out_layers[2].u;
  assign corners.layer2_v = out_layers[2].v;
  assign corners.last     = out_last;

  `TCTL_ASSERT_NXT(a_cell_capture, clk, rst, in_fire && cells.in_map, cell_valid && corner_cnt == CORNER_TL)
  `TCTL_ASSERT_IMP(a_count_in_cell, clk, rst, corner_cnt != CORNER_TL, cell_valid)
  `TCTL_ASSERT_NXT(a_corner_order, clk, rst, corners.valid && corners.ready && !corners.last, !corners.valid || corners.corner == $past(corners.corner) + 2'd1)

endmodule
